FILE: hw/rtl/msq_pkg.sv
package msq_pkg;

    localparam int DUTY_BITS_DEFAULT = 8;
    localparam int TIME_BITS_DEFAULT = 16;

    localparam int PROFILE_NUM = 5;
    localparam int PROFILE_BITS = 48;
    localparam int DUTY_FIELD_BITS = 8;
    localparam int TIME_FIELD_BITS = 16;

    // Register indexes on the write port
    localparam logic [2:0] REG_PROFILE_ONE = 3'd0;
    localparam logic [2:0] REG_PROFILE_TWO = 3'd1;
    localparam logic [2:0] REG_PROFILE_THREE = 3'd2;
    localparam logic [2:0] REG_PROFILE_FOUR = 3'd3;
    localparam logic [2:0] REG_PROFILE_FIVE = 3'd4;
    localparam logic [2:0] REG_PROFILE_COUNT = 3'd5;
    localparam logic [2:0] REG_MANUAL_DUTY = 3'd6;

    localparam logic [2:0] PROFILE_COUNT_RESET = 3'd5;
    localparam logic [2:0] PROFILE_COUNT_MAX = 3'd5;

    typedef enum logic [2:0] {
        CMD_TICK = 3'd0,
        CMD_PING = 3'd1,
        CMD_STOP = 3'd2,
        CMD_STRIKE = 3'd3,
        CMD_MAN_FWD = 3'd4,
        CMD_MAN_REV = 3'd5,
        CMD_UNKNOWN = 3'd6,
        CMD_LINK_LOST = 3'd7
    } cmd_code_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_PULL = 3'd1,
        MODE_FIRE = 3'd2,
        MODE_FWD = 3'd3,
        MODE_REV = 3'd4
    } motor_mode_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } dir_t;

    typedef enum logic [3:0] {
        REPLY_NONE = 4'd0,
        REPLY_PONG = 4'd1,
        REPLY_STOP_ACK = 4'd2,
        REPLY_STRIKE_ACK = 4'd3,
        REPLY_FWD_ACK = 4'd4,
        REPLY_REV_ACK = 4'd5,
        REPLY_DONE = 4'd6,
        REPLY_BAD_GEAR = 4'd7,
        REPLY_UNKNOWN = 4'd8
    } reply_t;

    typedef struct packed {
        cmd_code_t  mode;
        logic [2:0] gear;
    } cmd_t;

    typedef struct packed {
        logic                       drive_valid;
        dir_t                       drive_dir;
        logic [DUTY_FIELD_BITS-1:0] drive_duty;
        reply_t                     reply_code;
        logic [2:0]                 reply_gear;
    } rsp_t;

    typedef struct packed {
        logic [PROFILE_NUM-1:0][PROFILE_BITS-1:0] profile;
        logic [2:0]                               count;
        logic [DUTY_FIELD_BITS-1:0]               manual_duty;
    } cfg_t;

endpackage

FILE: hw/rtl/msq_cfg.sv
module msq_cfg #(
    parameter int DUTY_BITS = msq_pkg::DUTY_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [2:0]                      wr_index,
    input  logic [msq_pkg::PROFILE_BITS-1:0] wr_data,
    output msq_pkg::cfg_t                   cfg
);

    localparam int DW = (DUTY_BITS < msq_pkg::DUTY_FIELD_BITS) ?
                        DUTY_BITS : msq_pkg::DUTY_FIELD_BITS;

    logic [msq_pkg::PROFILE_NUM-1:0][msq_pkg::PROFILE_BITS-1:0] profile_reg;
    logic [2:0]    count_reg;
    logic [DW-1:0] manual_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg <= '0;
            count_reg   <= msq_pkg::PROFILE_COUNT_RESET;
            manual_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                msq_pkg::REG_PROFILE_ONE:   profile_reg[0] <= wr_data;
                msq_pkg::REG_PROFILE_TWO:   profile_reg[1] <= wr_data;
                msq_pkg::REG_PROFILE_THREE: profile_reg[2] <= wr_data;
                msq_pkg::REG_PROFILE_FOUR:  profile_reg[3] <= wr_data;
                msq_pkg::REG_PROFILE_FIVE:  profile_reg[4] <= wr_data;
                msq_pkg::REG_PROFILE_COUNT: count_reg <= wr_data[2:0];
                msq_pkg::REG_MANUAL_DUTY:   manual_reg <= wr_data[DW-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.profile     = profile_reg;
        cfg.count       = count_reg;
        cfg.manual_duty = msq_pkg::DUTY_FIELD_BITS'(manual_reg);
    end

endmodule

FILE: hw/rtl/msq_core.sv
module msq_core #(
    parameter int DUTY_BITS = msq_pkg::DUTY_BITS_DEFAULT,
    parameter int TIME_BITS = msq_pkg::TIME_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  msq_pkg::cmd_t item,
    input  msq_pkg::cfg_t cfg,
    output msq_pkg::rsp_t res
);

    localparam int DW = (DUTY_BITS < msq_pkg::DUTY_FIELD_BITS) ?
                        DUTY_BITS : msq_pkg::DUTY_FIELD_BITS;
    localparam int TW = (TIME_BITS < msq_pkg::TIME_FIELD_BITS) ?
                        TIME_BITS : msq_pkg::TIME_FIELD_BITS;
    localparam logic [msq_pkg::DUTY_FIELD_BITS-1:0] DUTY_MASK =
        msq_pkg::DUTY_FIELD_BITS'((1 << DW) - 1);

    msq_pkg::motor_mode_t mode_reg, mode_next;
    logic [2:0]           gear_reg, gear_next;
    logic [TW-1:0]        phase_reg, phase_next;

    logic [2:0]                       count;
    logic [2:0]                       req_idx, act_idx;
    logic [msq_pkg::PROFILE_BITS-1:0] req_prof, act_prof;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= msq_pkg::MODE_IDLE;
            gear_reg  <= '0;
            phase_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            gear_reg  <= gear_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        count = (cfg.count > msq_pkg::PROFILE_COUNT_MAX) ? msq_pkg::PROFILE_COUNT_MAX
                                                         : cfg.count;
        // gears outside 1..5 fall back to the first profile
        req_idx  = (item.gear >= 3'd1 && item.gear <= 3'd5) ? item.gear - 3'd1 : 3'd0;
        act_idx  = (gear_reg >= 3'd1 && gear_reg <= 3'd5) ? gear_reg - 3'd1 : 3'd0;
        req_prof = cfg.profile[req_idx];
        act_prof = cfg.profile[act_idx];
    end

    always_comb
    begin
        mode_next  = mode_reg;
        gear_next  = gear_reg;
        phase_next = phase_reg;
        res        = '0;

        unique case (item.mode)
            msq_pkg::CMD_TICK:
            begin
                if (mode_reg == msq_pkg::MODE_PULL || mode_reg == msq_pkg::MODE_FIRE)
                begin
                    if (phase_reg > TW'(1))
                    begin
                        phase_next = phase_reg - TW'(1);
                    end
                    else if (mode_reg == msq_pkg::MODE_PULL)
                    begin
                        mode_next       = msq_pkg::MODE_FIRE;
                        phase_next      = act_prof[TW-1:0];
                        res.drive_valid = 1'b1;
                        res.drive_dir   = msq_pkg::DIR_FWD;
                        res.drive_duty  = act_prof[23:16] & DUTY_MASK;
                    end
                    else
                    begin
                        mode_next       = msq_pkg::MODE_IDLE;
                        gear_next       = '0;
                        phase_next      = '0;
                        res.drive_valid = 1'b1;
                        res.reply_code  = msq_pkg::REPLY_DONE;
                        res.reply_gear  = gear_reg;
                    end
                end
            end
            msq_pkg::CMD_PING:
            begin
                res.reply_code = msq_pkg::REPLY_PONG;
            end
            msq_pkg::CMD_STOP:
            begin
                mode_next       = msq_pkg::MODE_IDLE;
                gear_next       = '0;
                phase_next      = '0;
                res.drive_valid = 1'b1;
                res.reply_code  = msq_pkg::REPLY_STOP_ACK;
            end
            msq_pkg::CMD_STRIKE:
            begin
                if (item.gear == 3'd0 || item.gear > count)
                begin
                    res.reply_code = msq_pkg::REPLY_BAD_GEAR;
                end
                else
                begin
                    mode_next       = msq_pkg::MODE_PULL;
                    gear_next       = item.gear;
                    phase_next      = req_prof[24 +: TW];
                    res.drive_valid = 1'b1;
                    res.drive_dir   = msq_pkg::DIR_REV;
                    res.drive_duty  = req_prof[47:40] & DUTY_MASK;
                    res.reply_code  = msq_pkg::REPLY_STRIKE_ACK;
                    res.reply_gear  = item.gear;
                end
            end
            msq_pkg::CMD_MAN_FWD:
            begin
                mode_next       = msq_pkg::MODE_FWD;
                gear_next       = '0;
                phase_next      = '0;
                res.drive_valid = 1'b1;
                res.drive_dir   = msq_pkg::DIR_FWD;
                res.drive_duty  = cfg.manual_duty;
                res.reply_code  = msq_pkg::REPLY_FWD_ACK;
            end
            msq_pkg::CMD_MAN_REV:
            begin
                mode_next       = msq_pkg::MODE_REV;
                gear_next       = '0;
                phase_next      = '0;
                res.drive_valid = 1'b1;
                res.drive_dir   = msq_pkg::DIR_REV;
                res.drive_duty  = cfg.manual_duty;
                res.reply_code  = msq_pkg::REPLY_REV_ACK;
            end
            msq_pkg::CMD_UNKNOWN:
            begin
                res.reply_code = msq_pkg::REPLY_UNKNOWN;
            end
            msq_pkg::CMD_LINK_LOST:
            begin
                // stop and clear, no reply
                mode_next       = msq_pkg::MODE_IDLE;
                gear_next       = '0;
                phase_next      = '0;
                res.drive_valid = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/motor_strike_sequencer.sv
// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid / cmd_stall  msq_pkg::cmd_t (mode, gear)
// rsp       out        rsp_valid / rsp_stall  msq_pkg::rsp_t (drive and reply)
// wr        in         wr_en                  wr_index, wr_data (48 bits)
//
// One request per cycle sustained while rsp_stall stays low; a taken request passes
// through the input register, then the result register, with the mode update
// done in the logic between them. Every request yields exactly one response.
// Reset (rst_n low, asynchronous) empties both registers, sets the motor idle and
// restores register defaults; no clearing pass follows.
// A stalled response holds; cmd_stall rises only while both registers are full.
module motor_strike_sequencer #(
    parameter int DUTY_BITS = msq_pkg::DUTY_BITS_DEFAULT,
    parameter int TIME_BITS = msq_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  msq_pkg::cmd_t                    cmd,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output msq_pkg::rsp_t                    rsp,
    input  logic                             wr_en,
    input  logic [2:0]                       wr_index,
    input  logic [msq_pkg::PROFILE_BITS-1:0] wr_data
);

    msq_pkg::cfg_t cfg;
    msq_pkg::cmd_t s1_item_reg;
    msq_pkg::rsp_t rsp_item_reg, core_res;
    logic          s1_valid_reg, s1_valid_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          take, advance;

    msq_cfg #(
        .DUTY_BITS(DUTY_BITS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    msq_core #(
        .DUTY_BITS(DUTY_BITS),
        .TIME_BITS(TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_comb
    begin
        // move the held request on whenever the result register frees up
        advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
        cmd_stall = s1_valid_reg && !advance;
        take      = cmd_valid && !cmd_stall;

        s1_valid_next = take || (s1_valid_reg && !advance);
        rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            s1_item_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (take)
            begin
                s1_item_reg <= cmd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_item_reg <= core_res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

endmodule

FILE: hw/rtl/msq_checker.sv
module msq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input msq_pkg::rsp_t rsp
);

    // no response may be shown while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_idle_drive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.drive_valid |->
            rsp.drive_dir == msq_pkg::DIR_STOP && rsp.drive_duty == '0)
        else $error("direction or duty set without a drive command");

    a_gear_reply: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.reply_gear != 3'd0 |->
            rsp.reply_code == msq_pkg::REPLY_STRIKE_ACK ||
            rsp.reply_code == msq_pkg::REPLY_DONE)
        else $error("gear reported on a reply that carries none");

    a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.reply_code == msq_pkg::REPLY_DONE |->
            rsp.drive_valid && rsp.drive_dir == msq_pkg::DIR_STOP &&
            rsp.reply_gear != 3'd0)
        else $error("done reply without a stop for a gear");

endmodule

bind motor_strike_sequencer msq_checker u_msq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: verif/msq_drive_checker.sv
module msq_drive_checker
    import msq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic                    cmd_stall,
    input  cmd_t                    cmd,
    input  logic                    rsp_valid,
    input  logic                    rsp_stall,
    input  rsp_t                    rsp,
    input  logic                    wr_en,
    input  logic [2:0]              wr_index,
    input  logic [PROFILE_BITS-1:0] wr_data,
    output int                      fail_count,
    output int                      replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    // Local copy of the registers
    logic [PROFILE_BITS-1:0]    gear_profiles [PROFILE_NUM];
    logic [2:0]                 gear_limit;
    logic [DUTY_FIELD_BITS-1:0] manual_level;

    // Local copy of the motor state
    motor_mode_t                motor_q;
    logic [2:0]                 gear_q;
    logic [TIME_FIELD_BITS-1:0] ms_left;

    rsp_t drive_replies [$];

    function automatic void park_motor();
        motor_q = MODE_IDLE;
        gear_q  = '0;
        ms_left = '0;
    endfunction

    // Advance the motor by one request and return the drive/reply it causes
    function automatic rsp_t step_motor(input cmd_t c);
        rsp_t                    r;
        logic [PROFILE_BITS-1:0] prof;
        logic [2:0]              usable_gears;
        r = '0;
        usable_gears = (gear_limit > PROFILE_COUNT_MAX) ? PROFILE_COUNT_MAX : gear_limit;
        case (c.mode)
            CMD_TICK:
            begin
                if (motor_q == MODE_PULL || motor_q == MODE_FIRE)
                begin
                    if (ms_left > 1)
                    begin
                        ms_left = ms_left - 1'b1;
                    end
                    else
                    begin
                        prof = gear_profiles[gear_q - 3'd1];
                        r.drive_valid = 1'b1;
                        if (motor_q == MODE_PULL)
                        begin
                            motor_q      = MODE_FIRE;
                            ms_left      = prof[15:0];
                            r.drive_dir  = DIR_FWD;
                            r.drive_duty = prof[23:16];
                        end
                        else
                        begin
                            r.drive_dir  = DIR_STOP;
                            r.reply_code = REPLY_DONE;
                            r.reply_gear = gear_q;
                            park_motor();
                        end
                    end
                end
            end
            CMD_PING:
            begin
                r.reply_code = REPLY_PONG;
            end
            CMD_STOP:
            begin
                park_motor();
                r.drive_valid = 1'b1;
                r.reply_code  = REPLY_STOP_ACK;
            end
            CMD_STRIKE:
            begin
                if (c.gear == 3'd0 || c.gear > usable_gears)
                begin
                    r.reply_code = REPLY_BAD_GEAR;
                end
                else
                begin
                    prof          = gear_profiles[c.gear - 3'd1];
                    motor_q       = MODE_PULL;
                    gear_q        = c.gear;
                    ms_left       = prof[39:24];
                    r.drive_valid = 1'b1;
                    r.drive_dir   = DIR_REV;
                    r.drive_duty  = prof[47:40];
                    r.reply_code  = REPLY_STRIKE_ACK;
                    r.reply_gear  = c.gear;
                end
            end
            CMD_MAN_FWD:
            begin
                park_motor();
                motor_q       = MODE_FWD;
                r.drive_valid = 1'b1;
                r.drive_dir   = DIR_FWD;
                r.drive_duty  = manual_level;
                r.reply_code  = REPLY_FWD_ACK;
            end
            CMD_MAN_REV:
            begin
                park_motor();
                motor_q       = MODE_REV;
                r.drive_valid = 1'b1;
                r.drive_dir   = DIR_REV;
                r.drive_duty  = manual_level;
                r.reply_code  = REPLY_REV_ACK;
            end
            CMD_UNKNOWN:
            begin
                r.reply_code = REPLY_UNKNOWN;
            end
            default:
            begin
                // link lost: stop silently
                park_motor();
                r.drive_valid = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < PROFILE_NUM; i++)
            begin
                gear_profiles[i] = '0;
            end
            gear_limit   = PROFILE_COUNT_RESET;
            manual_level = '0;
            park_motor();
            drive_replies.delete();
            fail_count  = 0;
            replies_due = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (drive_replies.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = drive_replies.pop_front();
                    check_field("drive_valid", want.drive_valid, rsp.drive_valid);
                    check_field("drive_dir", want.drive_dir, rsp.drive_dir);
                    check_field("drive_duty", want.drive_duty, rsp.drive_duty);
                    check_field("reply_code", want.reply_code, rsp.reply_code);
                    check_field("reply_gear", want.reply_gear, rsp.reply_gear);
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                drive_replies.push_back(step_motor(cmd));
            end
            if (wr_en)
            begin
                case (wr_index)
                    REG_PROFILE_ONE, REG_PROFILE_TWO, REG_PROFILE_THREE,
                    REG_PROFILE_FOUR, REG_PROFILE_FIVE:
                        gear_profiles[wr_index] = wr_data;
                    REG_PROFILE_COUNT:
                        gear_limit = wr_data[2:0];
                    REG_MANUAL_DUTY:
                        manual_level = wr_data[DUTY_FIELD_BITS-1:0];
                    default:
                        ;
                endcase
            end
            replies_due = drive_replies.size();
        end
    end

endmodule

FILE: verif/tb_motor_strike_sequencer.sv
module tb_motor_strike_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import msq_pkg::*;

    // Index beyond the register map; writes to it are dropped
    localparam logic [2:0] REG_INDEX_SPARE = 3'd7;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_kind_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cmd_valid;
    logic                    cmd_stall;
    cmd_t                    cmd;
    logic                    rsp_valid;
    logic                    rsp_stall;
    rsp_t                    rsp;
    logic                    wr_en;
    logic [2:0]              wr_index;
    logic [PROFILE_BITS-1:0] wr_data;

    int fail_count;
    int replies_due;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int long_hold_req = 0;

    logic [PROFILE_BITS-1:0] reg_image [8];

    motor_strike_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    msq_drive_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .fail_count  (fail_count),
        .replies_due (replies_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req != holds_served)
            begin
                hold_left = 80;
                holds_served = long_hold_req;
            end
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic [PROFILE_BITS-1:0] random_wide();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly short phases so strikes run to completion; now and then a long one
    function automatic logic [PROFILE_BITS-1:0] random_profile();
        logic [15:0] pull_ms;
        logic [15:0] strike_ms;
        pull_ms   = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        strike_ms = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        return {8'($urandom), pull_ms, 8'($urandom), strike_ms};
    endfunction

    task automatic set_idling(input idle_kind_t kind);
        case (kind)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 68; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 68; end
            default:       begin send_idle_pct = 21; stall_pct = 21; end
        endcase
    endtask

    task automatic fill_registers(input logic [2:0] count, input logic [7:0] duty);
        logic [PROFILE_BITS-1:0] noise;
        reg_image[REG_PROFILE_ONE]   = random_profile();
        reg_image[REG_PROFILE_TWO]   = random_profile();
        reg_image[REG_PROFILE_THREE] = random_profile();
        reg_image[REG_PROFILE_FOUR]  = random_profile();
        reg_image[REG_PROFILE_FIVE]  = random_profile();
        noise = random_wide();
        reg_image[REG_PROFILE_COUNT] = {noise[PROFILE_BITS-1:3], count};
        noise = random_wide();
        reg_image[REG_MANUAL_DUTY] = {noise[PROFILE_BITS-1:8], duty};
        reg_image[REG_INDEX_SPARE] = random_wide();
    endtask

    // Write every index, the spare one included, on consecutive cycles
    task automatic write_registers();
        for (int i = REG_PROFILE_ONE; i <= REG_INDEX_SPARE; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= 3'(i);
            wr_data  <= reg_image[i];
            @(negedge clk);
        end
        wr_en <= 1'b0;
    endtask

    // Drop valid and hold until every response is back
    task automatic await_replies();
        cmd_valid <= 1'b0;
        wait (replies_due == 0);
        @(negedge clk);
    endtask

    task automatic issue(input cmd_code_t m, input logic [2:0] g);
        cmd_t next;
        int   gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        next.mode = m;
        next.gear = g;
        cmd       <= next;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Ticks dominate so that strikes get through both phases
    task automatic issue_random();
        int         pick;
        logic [2:0] g;
        pick = $urandom_range(0, 99);
        g    = 3'($urandom);
        if (pick < 50)
        begin
            issue(CMD_TICK, g);
        end
        else if (pick < 72)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                g = 3'($urandom_range(1, 5));
            end
            issue(CMD_STRIKE, g);
        end
        else if (pick < 78) issue(CMD_STOP, g);
        else if (pick < 83) issue(CMD_MAN_FWD, g);
        else if (pick < 88) issue(CMD_MAN_REV, g);
        else if (pick < 92) issue(CMD_PING, g);
        else if (pick < 96) issue(CMD_UNKNOWN, g);
        else issue(CMD_LINK_LOST, g);
    endtask

    initial
    begin
        logic [2:0] count;
        logic [7:0] duty;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        wr_en     = 1'b0;
        wr_index  = '0;
        wr_data   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed profiles: all ones, zero-length pull, zero-length strike, all zeros
        reg_image[REG_PROFILE_ONE]   = {PROFILE_BITS{1'b1}};
        reg_image[REG_PROFILE_TWO]   = {8'h5A, 16'd0, 8'h80, 16'd1};
        reg_image[REG_PROFILE_THREE] = {8'h01, 16'd2, 8'hFE, 16'd0};
        reg_image[REG_PROFILE_FOUR]  = random_profile();
        reg_image[REG_PROFILE_FIVE]  = '0;
        reg_image[REG_PROFILE_COUNT] = {{(PROFILE_BITS-3){1'b0}}, PROFILE_COUNT_MAX};
        reg_image[REG_MANUAL_DUTY]   = {{(PROFILE_BITS-8){1'b0}}, 8'hFF};
        reg_image[REG_INDEX_SPARE]   = random_wide();
        write_registers();
        set_idling(IDLE_NONE);

        issue(CMD_PING, 3'd7);
        issue(CMD_UNKNOWN, 3'd5);
        issue(CMD_TICK, 3'd2);
        issue(CMD_STRIKE, 3'd0);
        issue(CMD_STRIKE, 3'd6);
        issue(CMD_STRIKE, 3'd7);
        issue(CMD_MAN_FWD, 3'd0);
        issue(CMD_MAN_FWD, 3'd3);
        issue(CMD_TICK, 3'd0);
        issue(CMD_MAN_REV, 3'd1);
        issue(CMD_STOP, 3'd0);
        issue(CMD_STOP, 3'd4);
        issue(CMD_LINK_LOST, 3'd6);
        // pull of 0 ms then strike of 1 ms: each ends on its first tick
        issue(CMD_STRIKE, 3'd2);
        issue(CMD_TICK, 3'd0);
        issue(CMD_TICK, 3'd0);
        // pull of 2 ms counts down once before firing
        issue(CMD_STRIKE, 3'd3);
        issue(CMD_TICK, 3'd0);
        issue(CMD_TICK, 3'd0);
        issue(CMD_TICK, 3'd0);
        // overrides of a running strike
        issue(CMD_STRIKE, 3'd1);
        issue(CMD_STRIKE, 3'd5);
        issue(CMD_TICK, 3'd0);
        issue(CMD_MAN_REV, 3'd0);
        issue(CMD_STRIKE, 3'd1);
        issue(CMD_LINK_LOST, 3'd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            await_replies();
            case (phase)
                0:       begin count = 3'd0; duty = 8'h00; end
                1:       begin count = 3'd7; duty = 8'hFF; end
                2:       begin count = 3'd6; duty = 8'($urandom); end
                default: begin count = 3'($urandom); duty = 8'($urandom); end
            endcase
            fill_registers(count, duty);
            write_registers();
            set_idling(idle_kind_t'(phase % 4));
            for (int k = 0; k < 110; k++)
            begin
                // fill the block against a held receiver
                if ((phase == 0 || phase == 4) && k == 30)
                begin
                    long_hold_req++;
                end
                if (phase == 3 && k == 60)
                begin
                    await_replies();
                end
                issue_random();
            end
        end

        cmd_valid <= 1'b0;
        wait (replies_due == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && replies_due == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: motor_strike_sequencer.f
hw/rtl/msq_pkg.sv
hw/rtl/msq_cfg.sv
hw/rtl/msq_core.sv
hw/rtl/motor_strike_sequencer.sv
hw/rtl/msq_checker.sv
verif/msq_drive_checker.sv
verif/tb_motor_strike_sequencer.sv
